[hdl/assert_macros.svh]
// Assertion macros used by the RTL of the diagonal window match counter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define DWMC_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

`define DWMC_NEVER(name, clk, rstn, expr) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define DWMC_ASSERT(name, clk, rstn, prop)

`define DWMC_NEVER(name, clk, rstn, expr)

`endif

`endif

[hdl/dwmc_pkg.sv]
// Types, constants and helper functions of the diagonal window match counter
`default_nettype none

package dwmc_pkg;

    localparam int BASE_BITS = 3;
    localparam int WIN_BITS  = 8;

    typedef logic [BASE_BITS-1:0] base_t;
    typedef logic [WIN_BITS-1:0]  win_t;

    // base codes: A C G T, then N and X (and unused codes) never match
    localparam base_t BASE_T = 3'd3;
    localparam base_t BASE_N = 3'd4;

    // configuration register indexes
    localparam logic CFG_WINDOW_SIZE = 1'b0;
    localparam logic CFG_REPORT_MIN  = 1'b1;

    localparam win_t WIN_SIZE_RESET   = 8'd20;
    localparam win_t MIN_MATCH_RESET  = 8'd14;

    typedef struct packed {
        logic reverse_mode;
        logic diag_start;
    } ctrl_t;

    typedef struct packed {
        win_t fill_level;
        win_t running_count;
        win_t win_eff;
    } status_t;

    function automatic base_t complement_base(input base_t b);
        base_t r;
        if (b < BASE_N)
            r = BASE_T - b;
        else
            r = b;
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/diagonal_window_match_counter_core.sv]
// An accepted pair waits in the input register; the single-pass window
// update then registers its result in the output register.
// Throughput: one base pair per cycle unless the output is stalled.
// Output stall backs up into the input register, then into in_stall.
// Reset: valid flags, window count, fill level and cursors clear;
// window_size returns to 20 and the report minimum to 14.
`default_nettype none

`include "assert_macros.svh"

module diagonal_window_match_counter_core #(
    parameter int WINDOW_MAX = 255,
    parameter int POS_BITS   = 20
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_we,
    input  wire                    cfg_index,
    input  wire  [7:0]             cfg_wdata,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire  [2:0]             top_base,
    input  wire  [2:0]             bot_base,
    input  wire                    reverse_mode,
    input  wire                    diag_start,
    input  wire  [POS_BITS-1:0]    top_start,
    input  wire  [POS_BITS-1:0]    bot_start,
    output logic                   out_valid,
    input  wire                    out_stall,
    output logic [POS_BITS-1:0]    top_pos,
    output logic [POS_BITS-1:0]    bot_pos,
    output logic [7:0]             match_count,
    output logic                   is_reverse
);
    import dwmc_pkg::*;

    ctrl_t   in_ctrl;
    ctrl_t   item_ctrl;
    base_t   item_top_base;
    base_t   item_bot_base;
    logic [POS_BITS-1:0] item_top_start;
    logic [POS_BITS-1:0] item_bot_start;
    logic    item_valid;
    logic    item_fire;
    logic    out_free;
    logic    res_valid;
    logic [POS_BITS-1:0] res_top_pos;
    logic [POS_BITS-1:0] res_bot_pos;
    win_t    res_count;
    status_t status;

    assign in_ctrl.reverse_mode = reverse_mode;
    assign in_ctrl.diag_start   = diag_start;

    dwmc_in_reg #(
        .POS_BITS (POS_BITS)
    ) u_in_reg (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .top_base       (top_base),
        .bot_base       (bot_base),
        .ctrl           (in_ctrl),
        .top_start      (top_start),
        .bot_start      (bot_start),
        .out_free       (out_free),
        .item_fire      (item_fire),
        .item_top_base  (item_top_base),
        .item_bot_base  (item_bot_base),
        .item_ctrl      (item_ctrl),
        .item_top_start (item_top_start),
        .item_bot_start (item_bot_start),
        .item_valid     (item_valid)
    );

    dwmc_window #(
        .WINDOW_MAX (WINDOW_MAX),
        .POS_BITS   (POS_BITS)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fire        (item_fire),
        .top_base    (item_top_base),
        .bot_base    (item_bot_base),
        .ctrl        (item_ctrl),
        .top_start   (item_top_start),
        .bot_start   (item_bot_start),
        .res_valid   (res_valid),
        .res_top_pos (res_top_pos),
        .res_bot_pos (res_bot_pos),
        .res_count   (res_count),
        .status      (status)
    );

    dwmc_out_reg #(
        .POS_BITS (POS_BITS)
    ) u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_valid   (res_valid),
        .res_top_pos (res_top_pos),
        .res_bot_pos (res_bot_pos),
        .res_count   (res_count),
        .res_reverse (item_ctrl.reverse_mode),
        .out_free    (out_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .top_pos     (top_pos),
        .bot_pos     (bot_pos),
        .match_count (match_count),
        .is_reverse  (is_reverse)
    );

    `DWMC_ASSERT(a_stall_only_when_full, clk, rst_n, in_stall |-> item_valid)
    `DWMC_NEVER(a_count_within_fill, clk, rst_n, status.running_count > status.fill_level)
    `DWMC_NEVER(a_fill_within_window, clk, rst_n, status.fill_level > status.win_eff)
    `DWMC_ASSERT(a_result_needs_item, clk, rst_n, res_valid |-> item_fire)

endmodule

`default_nettype wire

[hdl/dwmc_in_reg.sv]
// Input register stage holding one accepted base pair
`default_nettype none

module dwmc_in_reg #(
    parameter int POS_BITS = 20
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire  dwmc_pkg::base_t  top_base,
    input  wire  dwmc_pkg::base_t  bot_base,
    input  wire  dwmc_pkg::ctrl_t  ctrl,
    input  wire  [POS_BITS-1:0]    top_start,
    input  wire  [POS_BITS-1:0]    bot_start,
    input  wire                    out_free,
    output logic                   item_fire,
    output dwmc_pkg::base_t        item_top_base,
    output dwmc_pkg::base_t        item_bot_base,
    output dwmc_pkg::ctrl_t        item_ctrl,
    output logic [POS_BITS-1:0]    item_top_start,
    output logic [POS_BITS-1:0]    item_bot_start,
    output logic                   item_valid
);
    import dwmc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    base_t top_base_reg;
    base_t bot_base_reg;
    ctrl_t ctrl_reg;
    logic [POS_BITS-1:0] top_start_reg;
    logic [POS_BITS-1:0] bot_start_reg;
    logic  take;

    assign in_stall  = valid_reg && !out_free;
    assign take      = in_valid && !in_stall;
    assign item_fire = valid_reg && out_free;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (item_fire)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            top_base_reg  <= top_base;
            bot_base_reg  <= bot_base;
            ctrl_reg      <= ctrl;
            top_start_reg <= top_start;
            bot_start_reg <= bot_start;
        end
    end

    assign item_top_base  = top_base_reg;
    assign item_bot_base  = bot_base_reg;
    assign item_ctrl      = ctrl_reg;
    assign item_top_start = top_start_reg;
    assign item_bot_start = bot_start_reg;
    assign item_valid     = valid_reg;

endmodule

`default_nettype wire

[hdl/dwmc_window.sv]
// Window state, configuration registers and match/count/report logic
`default_nettype none

module dwmc_window #(
    parameter int WINDOW_MAX = 255,
    parameter int POS_BITS   = 20
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_we,
    input  wire                    cfg_index,
    input  wire  dwmc_pkg::win_t   cfg_wdata,
    input  wire                    fire,
    input  wire  dwmc_pkg::base_t  top_base,
    input  wire  dwmc_pkg::base_t  bot_base,
    input  wire  dwmc_pkg::ctrl_t  ctrl,
    input  wire  [POS_BITS-1:0]    top_start,
    input  wire  [POS_BITS-1:0]    bot_start,
    output logic                   res_valid,
    output logic [POS_BITS-1:0]    res_top_pos,
    output logic [POS_BITS-1:0]    res_bot_pos,
    output dwmc_pkg::win_t         res_count,
    output dwmc_pkg::status_t      status
);
    import dwmc_pkg::*;

    localparam win_t WMAX = WIN_BITS'(WINDOW_MAX);

    win_t window_size_reg;
    win_t report_min_reg;
    win_t fill_reg;
    win_t fill_next;
    win_t count_reg;
    win_t count_next;
    logic [POS_BITS-1:0] top_cur_reg;
    logic [POS_BITS-1:0] top_cur_next;
    logic [POS_BITS-1:0] bot_cur_reg;
    logic [POS_BITS-1:0] bot_cur_next;
    logic [WINDOW_MAX-1:0] bits_reg;

    win_t  win_eff;
    win_t  win_last;
    win_t  fill_base;
    win_t  count_base;
    base_t bot_cmp;
    logic  match;
    logic  full;

    always_comb
    begin
        if (window_size_reg == '0)
            win_eff = 8'd1;
        else if (window_size_reg > WMAX)
            win_eff = WMAX;
        else
            win_eff = window_size_reg;
    end

    assign win_last   = win_eff - 8'd1;
    assign bot_cmp    = ctrl.reverse_mode ? complement_base(bot_base) : bot_base;
    assign match      = (top_base < BASE_N) && (top_base == bot_cmp);
    assign fill_base  = ctrl.diag_start ? '0 : fill_reg;
    assign count_base = ctrl.diag_start ? '0 : count_reg;
    assign full       = fill_base >= win_eff;

    always_comb
    begin
        top_cur_next = ctrl.diag_start ? top_start : top_cur_reg;
        bot_cur_next = ctrl.diag_start ? bot_start : bot_cur_reg;
        if (full)
        begin
            fill_next    = fill_base;
            count_next   = count_base - {7'd0, bits_reg[0]} + {7'd0, match};
            top_cur_next = top_cur_next + 1'b1;
            bot_cur_next = bot_cur_next + 1'b1;
        end
        else
        begin
            fill_next  = fill_base + 8'd1;
            count_next = count_base + {7'd0, match};
        end
    end

    // the pair that completes the window is reported as well
    assign res_valid   = fire && (fill_next >= win_eff) && (count_next >= report_min_reg);
    assign res_top_pos = top_cur_next;
    assign res_bot_pos = bot_cur_next;
    assign res_count   = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WIN_SIZE_RESET;
            report_min_reg  <= MIN_MATCH_RESET;
            fill_reg        <= '0;
            count_reg       <= '0;
            top_cur_reg     <= '0;
            bot_cur_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_SIZE:
                begin
                    window_size_reg <= cfg_wdata;
                    fill_reg        <= '0;
                    count_reg       <= '0;
                end
                CFG_REPORT_MIN: report_min_reg <= cfg_wdata;
                default: ;
            endcase
        end
        else if (fire)
        begin
            fill_reg    <= fill_next;
            count_reg   <= count_next;
            top_cur_reg <= top_cur_next;
            bot_cur_reg <= bot_cur_next;
        end
    end

    // new bit enters at the window's far end and walks down to bit 0
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_bits
        logic upper;
        if (i < WINDOW_MAX - 1)
        begin : g_mid
            assign upper = bits_reg[i+1];
        end
        else
        begin : g_top
            assign upper = 1'b0;
        end

        always_ff @(posedge clk)
        begin
            if (fire)
                bits_reg[i] <= (win_last == WIN_BITS'(i)) ? match : upper;
        end
    end

    assign status.fill_level    = fill_reg;
    assign status.running_count = count_reg;
    assign status.win_eff       = win_eff;

endmodule

`default_nettype wire

[hdl/dwmc_out_reg.sv]
// Result register holding one reported window until transferred
`default_nettype none

module dwmc_out_reg #(
    parameter int POS_BITS = 20
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   res_valid,
    input  wire  [POS_BITS-1:0]   res_top_pos,
    input  wire  [POS_BITS-1:0]   res_bot_pos,
    input  wire  dwmc_pkg::win_t  res_count,
    input  wire                   res_reverse,
    output logic                  out_free,
    output logic                  out_valid,
    input  wire                   out_stall,
    output logic [POS_BITS-1:0]   top_pos,
    output logic [POS_BITS-1:0]   bot_pos,
    output dwmc_pkg::win_t        match_count,
    output logic                  is_reverse
);
    import dwmc_pkg::*;

    logic valid_reg;
    logic valid_next;
    logic [POS_BITS-1:0] top_pos_reg;
    logic [POS_BITS-1:0] bot_pos_reg;
    win_t count_reg;
    logic reverse_reg;

    assign out_free   = !valid_reg || !out_stall;
    assign valid_next = out_free ? res_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            top_pos_reg <= res_top_pos;
            bot_pos_reg <= res_bot_pos;
            count_reg   <= res_count;
            reverse_reg <= res_reverse;
        end
    end

    assign out_valid   = valid_reg;
    assign top_pos     = top_pos_reg;
    assign bot_pos     = bot_pos_reg;
    assign match_count = count_reg;
    assign is_reverse  = reverse_reg;

endmodule

`default_nettype wire

[test/diagonal_window_match_counter_core_tb.sv]
// Self-checking testbench for diagonal_window_match_counter_core: directed rows, random diagonals
`default_nettype none

module diagonal_window_match_counter_core_tb;
    import dwmc_pkg::*;

    localparam int POS_BITS = 20;
    localparam logic [POS_BITS-1:0] P_MAX = 20'hFFFFF;

    localparam base_t NT_A  = 3'd0;
    localparam base_t NT_C  = 3'd1;
    localparam base_t NT_G  = 3'd2;
    localparam base_t NT_T  = 3'd3;
    localparam base_t NT_N  = 3'd4;
    localparam base_t NT_X  = 3'd5;
    localparam base_t NT_U6 = 3'd6;
    localparam base_t NT_U7 = 3'd7;

    typedef struct packed {
        base_t               top_base;
        base_t               bot_base;
        logic                reverse_mode;
        logic                diag_start;
        logic [POS_BITS-1:0] top_start;
        logic [POS_BITS-1:0] bot_start;
    } pair_t;

    typedef struct packed {
        logic [POS_BITS-1:0] top_pos;
        logic [POS_BITS-1:0] bot_pos;
        win_t                count;
        logic                rev;
    } hit_t;

    typedef struct packed {
        logic                cfg_first;
        win_t                cwin;
        win_t                cmin;
        logic [7:0]          reps;
        base_t               top_b;
        base_t               bot_b;
        logic                rev;
        logic                diag;
        logic [POS_BITS-1:0] ts;
        logic [POS_BITS-1:0] bs;
        logic                typed;
        logic [POS_BITS-1:0] wtop;
        logic [POS_BITS-1:0] wbot;
        win_t                wcnt;
        logic                wrev;
    } drow_t;

    typedef struct packed {
        win_t        win;
        win_t        minm;
        logic [15:0] items;
        logic [7:0]  match_pct;
        logic [7:0]  diag_pct;
        logic        calm;
    } phase_t;

    // cfg, win, min, reps, top, bot, rev, diag, top_start, bot_start, typed, expected hit
    drow_t steps [21] = '{
        '{0, 0, 0, 19, NT_A,  NT_A,  0, 0, 0,     0,     0, 0,     0,     0,  0},
        '{0, 0, 0, 1,  NT_A,  NT_A,  0, 0, 0,     0,     1, 0,     0,     20, 0},
        '{0, 0, 0, 1,  NT_A,  NT_A,  0, 0, 0,     0,     1, 1,     1,     20, 0},
        '{1, 1, 0, 1,  NT_A,  NT_A,  0, 0, 0,     0,     1, 1,     1,     1,  0},
        '{0, 0, 0, 1,  NT_N,  NT_N,  0, 0, 0,     0,     1, 2,     2,     0,  0},
        '{0, 0, 0, 1,  NT_X,  NT_X,  0, 0, 0,     0,     1, 3,     3,     0,  0},
        '{0, 0, 0, 1,  NT_U6, NT_U6, 0, 0, 0,     0,     1, 4,     4,     0,  0},
        '{0, 0, 0, 1,  NT_U7, NT_U7, 0, 0, 0,     0,     1, 5,     5,     0,  0},
        '{0, 0, 0, 1,  NT_G,  NT_G,  0, 1, P_MAX, 0,     1, P_MAX, 0,     1,  0},
        '{0, 0, 0, 1,  NT_T,  NT_A,  1, 0, 0,     0,     1, 0,     1,     1,  1},
        '{0, 0, 0, 1,  NT_C,  NT_G,  1, 0, 0,     0,     1, 1,     2,     1,  1},
        '{0, 0, 0, 1,  NT_A,  NT_A,  1, 0, 0,     0,     1, 2,     3,     0,  1},
        '{0, 0, 0, 1,  NT_N,  NT_N,  1, 0, 0,     0,     1, 3,     4,     0,  1},
        '{0, 0, 0, 1,  NT_U7, NT_U7, 1, 0, 0,     0,     1, 4,     5,     0,  1},
        '{0, 0, 0, 1,  NT_T,  NT_T,  0, 1, 0,     P_MAX, 1, 0,     P_MAX, 1,  0},
        '{0, 0, 0, 1,  NT_C,  NT_C,  0, 0, 0,     0,     1, 1,     0,     1,  0},
        '{0, 0, 0, 1,  NT_X,  NT_X,  0, 1, P_MAX, P_MAX, 1, P_MAX, P_MAX, 0,  0},
        '{0, 0, 0, 1,  NT_A,  NT_T,  1, 0, 0,     0,     0, 0,     0,     0,  0},
        '{0, 0, 0, 1,  NT_G,  NT_C,  0, 0, 0,     0,     0, 0,     0,     0,  0},
        '{1, 2, 1, 1,  NT_C,  NT_C,  0, 1, 5,     9,     0, 0,     0,     0,  0},
        '{0, 0, 0, 1,  NT_G,  NT_C,  1, 0, 0,     0,     0, 0,     0,     0,  0}
    };

    // window, min, pairs, match %, diag start %, no idling
    phase_t phases [6] = '{
        '{8'd3,   8'd2,   16'd20,  8'd70,  8'd6,  1'b0},
        '{8'd0,   8'd0,   16'd15,  8'd40,  8'd10, 1'b0},
        '{8'd20,  8'd14,  16'd40,  8'd85,  8'd2,  1'b1},
        '{8'd1,   8'd1,   16'd15,  8'd50,  8'd10, 1'b0},
        '{8'd255, 8'd255, 16'd262, 8'd100, 8'd0,  1'b0},
        '{8'd6,   8'd6,   16'd20,  8'd90,  8'd4,  1'b0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [7:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [POS_BITS-1:0] top_pos;
    logic [POS_BITS-1:0] bot_pos;
    logic [7:0] match_count;
    logic is_reverse;

    pair_t drv = '0;
    logic drv_typed = 1'b0;
    hit_t drv_want = '0;

    // window model
    win_t cfg_win = WIN_SIZE_RESET;
    win_t cfg_min = MIN_MATCH_RESET;
    bit win_hist [255];
    int unsigned win_count = 0;
    int unsigned win_fill = 0;
    logic [POS_BITS-1:0] top_cur = '0;
    logic [POS_BITS-1:0] bot_cur = '0;

    hit_t pending_hits [$];
    int idle_pct = 19;
    int pairs_in = 0;
    int hits_checked = 0;
    int bad_count = 0;
    int settings_seen = 1;

    diagonal_window_match_counter_core #(
        .WINDOW_MAX(255),
        .POS_BITS(POS_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .top_base(drv.top_base),
        .bot_base(drv.bot_base),
        .reverse_mode(drv.reverse_mode),
        .diag_start(drv.diag_start),
        .top_start(drv.top_start),
        .bot_start(drv.bot_start),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .top_pos(top_pos),
        .bot_pos(bot_pos),
        .match_count(match_count),
        .is_reverse(is_reverse)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_window();
        foreach (win_hist[i])
            win_hist[i] = 1'b0;
        win_count = 0;
        win_fill = 0;
    endfunction

    // Advances the window by one pair; returns 1 when the window is reported.
    function automatic bit score_pair(input pair_t p, output hit_t h);
        int unsigned w;
        base_t b;
        bit m;
        w = (cfg_win == 0) ? 1 : cfg_win;
        if (p.diag_start)
        begin
            clear_window();
            top_cur = p.top_start;
            bot_cur = p.bot_start;
        end
        b = p.bot_base;
        if (p.reverse_mode && b < NT_N)
            b = NT_T - b;
        m = (p.top_base < NT_N) && (p.top_base == b);
        if (win_fill < w)
            win_fill++;
        else
        begin
            win_count -= win_hist[w-1];
            top_cur++;
            bot_cur++;
        end
        for (int i = 254; i > 0; i--)
            win_hist[i] = win_hist[i-1];
        win_hist[0] = m;
        win_count = (win_count + m) & 8'hFF;
        h = '{top_cur, bot_cur, win_t'(win_count), p.reverse_mode};
        return (win_fill >= w) && (win_count >= cfg_min);
    endfunction

    function automatic void note_bad(input string why, input hit_t want, input hit_t got);
        bad_count++;
        if (bad_count <= 10)
            $display("%s: expected top %h bot %h count %0d rev %0d, ",
                     why, want.top_pos, want.bot_pos, want.count, want.rev,
                     "got top %h bot %h count %0d rev %0d",
                     got.top_pos, got.bot_pos, got.count, got.rev);
    endfunction

    always @(posedge clk)
    begin
        hit_t h;
        hit_t got;
        hit_t want;
        bit seen;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                seen = score_pair(drv, h);
                if (drv_typed)
                    pending_hits.push_back(drv_want);
                else if (seen)
                    pending_hits.push_back(h);
                pairs_in++;
            end
            if (out_valid && !out_stall)
            begin
                got = '{top_pos, bot_pos, match_count, is_reverse};
                if (pending_hits.size() == 0)
                    note_bad("unexpected report", '0, got);
                else
                begin
                    want = pending_hits.pop_front();
                    if (got.top_pos != want.top_pos || got.bot_pos != want.bot_pos ||
                        got.count != want.count || got.rev != want.rev)
                        note_bad("report mismatch", want, got);
                    hits_checked++;
                end
            end
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < idle_pct);

    task automatic send_pair(input pair_t p, input logic typed, input hit_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        drv <= p;
        drv_typed <= typed;
        drv_want <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic set_reg(input logic idx, input win_t val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_hits.size() != 0)
            @(posedge clk);
        // items without a report may still be in flight
        repeat (6) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WINDOW_SIZE)
        begin
            cfg_win = val;
            clear_window();
            settings_seen++;
        end
        else
            cfg_min = val;
    endtask

    initial
    begin
        pair_t p;
        hit_t want;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
        begin
            if (steps[i].cfg_first)
            begin
                set_reg(CFG_WINDOW_SIZE, steps[i].cwin);
                set_reg(CFG_REPORT_MIN, steps[i].cmin);
            end
            p = '{steps[i].top_b, steps[i].bot_b, steps[i].rev, steps[i].diag,
                  steps[i].ts, steps[i].bs};
            want = '{steps[i].wtop, steps[i].wbot, steps[i].wcnt, steps[i].wrev};
            repeat (steps[i].reps)
                send_pair(p, steps[i].typed, want);
        end

        foreach (phases[k])
        begin
            set_reg(CFG_WINDOW_SIZE, phases[k].win);
            set_reg(CFG_REPORT_MIN, phases[k].minm);
            idle_pct = phases[k].calm ? 0 : 19;
            for (int j = 0; j < phases[k].items; j++)
            begin
                p.reverse_mode = 1'($urandom_range(1));
                p.diag_start = (j == 0) ? 1'($urandom_range(1))
                                        : ($urandom_range(99) < phases[k].diag_pct);
                p.top_start = POS_BITS'($urandom);
                p.bot_start = POS_BITS'($urandom);
                if ($urandom_range(99) < phases[k].match_pct)
                begin
                    p.top_base = base_t'($urandom_range(3));
                    p.bot_base = p.reverse_mode ? NT_T - p.top_base : p.top_base;
                end
                else
                begin
                    p.top_base = base_t'($urandom_range(7));
                    p.bot_base = base_t'($urandom_range(7));
                end
                send_pair(p, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        idle_pct = 0;
        @(posedge clk);
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d base pairs across %0d window settings, %0d reports checked, %0d bad",
                 pairs_in, settings_seen, hits_checked, bad_count);
        if (bad_count == 0)
            $display("** diagonal_window_match_counter_core: PASSED **");
        else
            $display("** diagonal_window_match_counter_core: FAILED **");
        $finish;
    end

    initial
    begin
        #2400000;
        $display("timeout with %0d reports pending", pending_hits.size());
        $display("** diagonal_window_match_counter_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+hdl
hdl/dwmc_pkg.sv
hdl/dwmc_in_reg.sv
hdl/dwmc_window.sv
hdl/dwmc_out_reg.sv
hdl/diagonal_window_match_counter_core.sv
test/diagonal_window_match_counter_core_tb.sv
